// ===== rtl/ddsa_pkg.sv =====
package ddsa_pkg;

  localparam int unsigned MaxDigits = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned CntW      = $clog2(MaxDigits + 1);
  localparam int unsigned OpAddrW   = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
  localparam int unsigned SumDepth  = MaxDigits + 1;
  localparam int unsigned SumAddrW  = $clog2(SumDepth);
  localparam int unsigned DecBase   = 10;
  localparam int unsigned DigitMax  = 9;

  typedef struct packed {
    logic              operand_select;
    logic [DigitW-1:0] digit;
    logic              digit_valid;
    logic              end_of_operand;
  } in_item_t;

  typedef struct packed {
    logic [DigitW-1:0] sum_digit;
    logic              digit_present;
    logic              last_digit;
    logic              overflow;
  } out_item_t;

endpackage

// ===== rtl/ddsa_ram.sv =====
module ddsa_ram #(
  parameter int unsigned DATA_W = 4,
  parameter int unsigned DEPTH  = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ddsa_digit_adder.sv =====
module ddsa_digit_adder (
  input  logic [ddsa_pkg::DigitW-1:0] a_i,
  input  logic [ddsa_pkg::DigitW-1:0] b_i,
  input  logic                        carry_i,
  output logic [ddsa_pkg::DigitW-1:0] digit_o,
  output logic                        carry_o
);

  logic [ddsa_pkg::DigitW:0] raw;

  always_comb begin
    raw = {1'b0, a_i} + {1'b0, b_i} + {{ddsa_pkg::DigitW{1'b0}}, carry_i};
    if (raw >= (ddsa_pkg::DigitW + 1)'(ddsa_pkg::DecBase)) begin
      digit_o = ddsa_pkg::DigitW'(raw - (ddsa_pkg::DigitW + 1)'(ddsa_pkg::DecBase));
      carry_o = 1'b1;
    end else begin
      digit_o = ddsa_pkg::DigitW'(raw);
      carry_o = 1'b0;
    end
  end

endmodule

// ===== rtl/decimal_digit_string_adder.sv =====
// Loading: one input item per cycle while in S_LOAD; digits go straight into the operand RAMs.
// The closing item starts the adder: per column a RAM read, then add and write,
// over len = longer operand columns; then per sum digit a sum RAM read and output load,
// preceded by a carry digit if there is one. An empty pair gives a single last item
// with no digit present; output stalls hold the emission.
// Reset (rst_ni low, async) clears counts, flags and the output valid; RAM contents stay.
module decimal_digit_string_adder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ddsa_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ddsa_pkg::out_item_t out_item_o
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD,
    S_ADD,
    S_ECARRY,
    S_ERD,
    S_EDAT,
    S_EMPTY
  } state_e;

  localparam logic [ddsa_pkg::CntW-1:0]   MaxCnt  = ddsa_pkg::CntW'(ddsa_pkg::MaxDigits);
  localparam logic [ddsa_pkg::DigitW-1:0] DigMax  = ddsa_pkg::DigitW'(ddsa_pkg::DigitMax);
  localparam logic [ddsa_pkg::CntW-1:0]   OneCnt  = ddsa_pkg::CntW'(1);

  state_e                      state_q;
  logic [ddsa_pkg::CntW-1:0]   f_cnt_q, s_cnt_q;
  logic                        f_end_q, s_end_q, ovf_q;
  logic [ddsa_pkg::CntW-1:0]   col_q, len_q, idx_q;
  logic                        carry_q;
  logic                        out_valid_q;
  ddsa_pkg::out_item_t         out_item_q;

  logic                        in_acc, sel_first, open_op, store, room;
  logic [ddsa_pkg::CntW-1:0]   sel_cnt, f_cnt_d, s_cnt_d, len_d;
  logic                        f_we, s_we, f_end_d, s_end_d, ovf_d, done;
  logic [ddsa_pkg::DigitW-1:0] digit_sat;
  logic                        op_re;
  logic [ddsa_pkg::OpAddrW-1:0] f_raddr, s_raddr;
  logic [ddsa_pkg::DigitW-1:0] f_rdata, s_rdata, f_col, s_col;
  logic [ddsa_pkg::DigitW-1:0] add_digit;
  logic                        add_carry;
  logic                        sum_we, sum_re;
  logic [ddsa_pkg::SumAddrW-1:0] sum_waddr;
  logic [ddsa_pkg::DigitW-1:0] sum_rdata;
  logic                        slot_free;
  logic                        emit;
  logic                        out_valid_d;

  assign in_ready_o  = (state_q == S_LOAD);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit        = slot_free && ((state_q == S_ECARRY) || (state_q == S_EDAT) ||
                                     (state_q == S_EMPTY));
  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_comb begin
    digit_sat = (in_item_i.digit > DigMax) ? DigMax : in_item_i.digit;
    sel_first = !in_item_i.operand_select;
    open_op   = sel_first ? !f_end_q : !s_end_q;
    sel_cnt   = sel_first ? f_cnt_q : s_cnt_q;
    store     = in_acc && open_op && in_item_i.digit_valid;
    room      = (sel_cnt < MaxCnt);
    f_we      = store && room && sel_first;
    s_we      = store && room && !sel_first;
    ovf_d     = ovf_q || (store && !room);
    f_cnt_d   = f_cnt_q + ddsa_pkg::CntW'(f_we);
    s_cnt_d   = s_cnt_q + ddsa_pkg::CntW'(s_we);
    f_end_d   = f_end_q || (in_acc && sel_first && in_item_i.end_of_operand);
    s_end_d   = s_end_q || (in_acc && !sel_first && in_item_i.end_of_operand);
    done      = in_acc && f_end_d && s_end_d;
    len_d     = (f_cnt_d > s_cnt_d) ? f_cnt_d : s_cnt_d;
  end

  // column col counts from the least significant end
  always_comb begin
    op_re     = (state_q == S_RD);
    f_raddr   = ddsa_pkg::OpAddrW'(f_cnt_q - OneCnt - col_q);
    s_raddr   = ddsa_pkg::OpAddrW'(s_cnt_q - OneCnt - col_q);
    f_col     = (col_q < f_cnt_q) ? f_rdata : '0;
    s_col     = (col_q < s_cnt_q) ? s_rdata : '0;
    sum_we    = (state_q == S_ADD);
    sum_waddr = ddsa_pkg::SumAddrW'(len_q - col_q);
    sum_re    = (state_q == S_ERD);
  end

  ddsa_ram #(
    .DATA_W (ddsa_pkg::DigitW),
    .DEPTH  (ddsa_pkg::MaxDigits)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (sel_cnt[ddsa_pkg::OpAddrW-1:0]),
    .wdata_i (digit_sat),
    .re_i    (op_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  ddsa_ram #(
    .DATA_W (ddsa_pkg::DigitW),
    .DEPTH  (ddsa_pkg::MaxDigits)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (sel_cnt[ddsa_pkg::OpAddrW-1:0]),
    .wdata_i (digit_sat),
    .re_i    (op_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  ddsa_digit_adder u_adder (
    .a_i     (f_col),
    .b_i     (s_col),
    .carry_i (carry_q),
    .digit_o (add_digit),
    .carry_o (add_carry)
  );

  // sum digit at index len - col; index 0 (the carry) lives in carry_q
  ddsa_ram #(
    .DATA_W (ddsa_pkg::DigitW),
    .DEPTH  (ddsa_pkg::SumDepth)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (add_digit),
    .re_i    (sum_re),
    .raddr_i (idx_q[ddsa_pkg::SumAddrW-1:0]),
    .rdata_o (sum_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      f_cnt_q     <= '0;
      s_cnt_q     <= '0;
      f_end_q     <= 1'b0;
      s_end_q     <= 1'b0;
      ovf_q       <= 1'b0;
      col_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            f_cnt_q <= f_cnt_d;
            s_cnt_q <= s_cnt_d;
            f_end_q <= f_end_d;
            s_end_q <= s_end_d;
            ovf_q   <= ovf_d;
            if (done) begin
              len_q   <= len_d;
              col_q   <= '0;
              carry_q <= 1'b0;
              state_q <= (len_d == '0) ? S_EMPTY : S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          carry_q <= add_carry;
          col_q   <= col_q + OneCnt;
          if (col_q == len_q - OneCnt) begin
            idx_q   <= OneCnt;
            state_q <= add_carry ? S_ECARRY : S_ERD;
          end else begin
            state_q <= S_RD;
          end
        end
        S_ECARRY: begin
          if (slot_free) begin
            out_item_q.sum_digit     <= ddsa_pkg::DigitW'(carry_q);
            out_item_q.digit_present <= 1'b1;
            out_item_q.last_digit    <= 1'b0;
            out_item_q.overflow      <= ovf_q;
            state_q                  <= S_ERD;
          end
        end
        S_ERD: begin
          state_q <= S_EDAT;
        end
        S_EDAT: begin
          if (slot_free) begin
            out_item_q.sum_digit     <= sum_rdata;
            out_item_q.digit_present <= 1'b1;
            out_item_q.last_digit    <= (idx_q == len_q);
            out_item_q.overflow      <= ovf_q;
            if (idx_q == len_q) begin
              f_cnt_q <= '0;
              s_cnt_q <= '0;
              f_end_q <= 1'b0;
              s_end_q <= 1'b0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              idx_q   <= idx_q + OneCnt;
              state_q <= S_ERD;
            end
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            out_item_q.sum_digit     <= '0;
            out_item_q.digit_present <= 1'b0;
            out_item_q.last_digit    <= 1'b1;
            out_item_q.overflow      <= ovf_q;
            f_cnt_q                  <= '0;
            s_cnt_q                  <= '0;
            f_end_q                  <= 1'b0;
            s_end_q                  <= 1'b0;
            ovf_q                    <= 1'b0;
            state_q                  <= S_LOAD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_cnt_q <= MaxCnt) && (s_cnt_q <= MaxCnt))
    else $error("operand count beyond capacity");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.digit_present) |-> out_item_o.last_digit)
    else $error("empty result not marked last");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.sum_digit <= DigMax))
    else $error("sum digit out of decimal range");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |=> !in_ready_o)
    else $error("input taken during add");
`endif

endmodule
